[hw/rtl/bgts_pkg.sv]
// Shared types and codes for the burst-goodness task scheduler.
package bgts_pkg;

	typedef enum logic [1:0] {
		OP_SCHED = 2'd0,
		OP_NEW   = 2'd1,
		OP_ACT   = 2'd2,
		OP_DEACT = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  task_slot;
		logic [31:0] time_now;
	} req_t;

	typedef struct packed {
		logic [3:0] next_task;
		logic       switched;
	} rsp_t;

	// Multiplier digit for the goodness product.
	localparam int unsigned DIGIT_BITS = 8;

endpackage

[hw/rtl/bgts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bgts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/burst_goodness_task_scheduler.sv]
// Schedule op: the time from accept to result is set by the per-slot scan, in which each queued
// slot record is read from the table RAM and, for slots other than slot 0, its goodness is built
// up 8 multiplier bits a cycle. The divide by 3 of the burst smoothing runs shift-add steps, a
// remainder step and then correction steps that step the remainder down by 3.
// Other ops read and write back the slot record, then give the result; ignored ops go straight to the result.
// One transaction in flight; the next is taken once the result sits in the output register.
// Reset (arst_n low) clears control state and valid bits at once; no clearing pass.
module burst_goodness_task_scheduler #(
	parameter int unsigned TASK_SLOTS      = 16,
	parameter int unsigned TIME_BITS       = 32,
	parameter int unsigned BURST_FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bgts_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bgts_pkg::rsp_t rsp
);
	import bgts_pkg::*;

	localparam int unsigned SW  = $clog2(TASK_SLOTS);
	localparam int unsigned TW  = TIME_BITS;
	localparam int unsigned F   = BURST_FRAC_BITS;
	localparam int unsigned EW  = TW + F;
	localparam int unsigned XW  = EW + 2;
	localparam int unsigned AW  = EW + 1;
	localparam int unsigned BW  = TW + 1;
	localparam int unsigned ND  = (BW + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int unsigned BPW = ND * DIGIT_BITS;
	localparam int unsigned PW  = AW + BW;
	localparam int unsigned CW  = $clog2(XW);
	localparam int unsigned DW  = (ND > 1) ? $clog2(ND) : 1;

	typedef struct packed {
		logic [EW-1:0] eb;
		logic [TW-1:0] lb;
		logic [TW-1:0] st;
		logic [TW-1:0] sp;
		logic [TW-1:0] qt;
	} rec_t;

	localparam int unsigned RW = $bits(rec_t);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_DIV, ST_SMWR, ST_SADDR, ST_SDATA,
		ST_MUL, ST_CMP, ST_FIN, ST_WPICK, ST_DONE
	} state_t;

	state_t state_q;

	op_t              op_q;
	logic [SW-1:0]    slot_q;
	logic [TW-1:0]    now_q;
	logic [SW-1:0]    run_q;
	logic [EW-1:0]    fork_q;
	logic             sw_q;
	logic [TASK_SLOTS-1:0] queued_q;
	logic [TASK_SLOTS-1:0] vld_q;
	logic             rd_vld_q;

	rec_t             cur_q;
	rec_t             cand_q;
	rec_t             pick_rec_q;
	logic [SW-1:0]    pick_q;
	logic [SW-1:0]    scan_q;
	logic             any_q;
	logic [EW-1:0]    min_q;
	logic [EW-1:0]    e0_q;
	logic [PW-1:0]    best_q;
	logic [PW-1:0]    acc_q;
	logic [AW-1:0]    a_q;
	logic [BPW-1:0]   b_q;
	logic [DW-1:0]    dcnt_q;
	logic [XW-1:0]    x_q;
	logic [XW-1:0]    quo_q;
	logic [5:0]       rem_q;
	logic [CW-1:0]    cnt_q;

	logic             we;
	logic [SW-1:0]    waddr;
	rec_t             wrec;
	logic [SW-1:0]    raddr;
	logic [RW-1:0]    ram_rdata;
	rec_t             rec;
	rec_t             op_rec;
	logic             req_ok;
	logic             slot_ok;
	logic [AW+DIGIT_BITS-1:0] prod;
	logic             last_slot;
	logic [BW-1:0]    wait_w;

	bgts_ram #(.WIDTH(RW), .DEPTH(TASK_SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wrec),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// Never-written entries read as the reset record.
	assign rec = rd_vld_q ? rec_t'(ram_rdata) : '0;

	assign req_stall = (state_q != ST_IDLE);
	assign req_ok    = req_valid && !req_stall;
	assign slot_ok   = (req.task_slot != 4'd0) && (32'(req.task_slot) < TASK_SLOTS);
	assign last_slot = (scan_q == SW'(TASK_SLOTS - 1));

	assign prod   = a_q * b_q[BPW-1 -: DIGIT_BITS];
	assign wait_w = BW'(TW'(now_q - rec.qt)) + BW'(1);

	always_comb begin
		raddr = scan_q;
		if (state_q == ST_IDLE) begin
			raddr = (req.op == OP_SCHED) ? run_q : SW'(req.task_slot);
		end
	end

	// Record written back by ops 1 to 3.
	always_comb begin
		op_rec = rec;
		case (op_q)
			OP_NEW: begin
				op_rec.st = '0;
				op_rec.sp = '0;
				op_rec.lb = '0;
				op_rec.eb = fork_q;
				op_rec.qt = now_q;
			end
			OP_ACT: begin
				if (!queued_q[slot_q]) begin
					if (rec.qt > rec.sp) begin
						op_rec.sp = rec.qt;
					end
					op_rec.qt = now_q;
				end
			end
			OP_DEACT: begin
				if (queued_q[slot_q]) begin
					op_rec.sp = now_q;
				end
			end
			default: begin
				op_rec = rec;
			end
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = run_q;
		wrec  = cur_q;
		case (state_q)
			ST_RD: begin
				if (op_q != OP_SCHED) begin
					we    = 1'b1;
					waddr = slot_q;
					wrec  = op_rec;
				end
			end
			ST_SMWR: begin
				we      = 1'b1;
				wrec.eb = quo_q[EW-1:0];
				wrec.lb = now_q - cur_q.st;
			end
			ST_FIN: begin
				we      = any_q && (pick_q != run_q);
				wrec.sp = now_q;
			end
			ST_WPICK: begin
				we      = 1'b1;
				waddr   = pick_q;
				wrec    = pick_rec_q;
				wrec.st = now_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			run_q     <= '0;
			fork_q    <= '0;
			queued_q  <= TASK_SLOTS'(1);
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			rsp_valid <= 1'b0;
			sw_q      <= 1'b0;
			any_q     <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[raddr];
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (rsp_valid && !rsp_stall && state_q != ST_DONE) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_ok) begin
						op_q   <= req.op;
						slot_q <= SW'(req.task_slot);
						now_q  <= TW'(req.time_now);
						sw_q   <= 1'b0;
						if (req.op == OP_SCHED || slot_ok) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RD: begin
					cur_q <= rec;
					if (op_q == OP_SCHED) begin
						x_q     <= (XW'(rec.lb) << (F + 1)) + XW'(rec.eb);
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						case (op_q)
							OP_NEW:   queued_q[slot_q] <= 1'b1;
							OP_ACT:   queued_q[slot_q] <= 1'b1;
							OP_DEACT: queued_q[slot_q] <= 1'b0;
							default:  queued_q[slot_q] <= queued_q[slot_q];
						endcase
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					// x/3 as x*(1/4)(1+1/4)(1+1/16)...; the estimate never exceeds the
					// quotient, the small remainder is then stepped down by 3
					case (cnt_q)
						CW'(0): quo_q <= (x_q >> 2) + (x_q >> 4);
						CW'(1): quo_q <= quo_q + (quo_q >> 4);
						CW'(2): quo_q <= quo_q + (quo_q >> 8);
						CW'(3): quo_q <= quo_q + (quo_q >> 16);
						CW'(4): quo_q <= quo_q + (quo_q >> 32);
						CW'(5): rem_q <= 6'(x_q - quo_q - (quo_q << 1));
						default: begin
							if (rem_q >= 6'd3) begin
								quo_q <= quo_q + XW'(1);
								rem_q <= rem_q - 6'd3;
							end else begin
								state_q <= ST_SMWR;
							end
						end
					endcase
					if (cnt_q != CW'(6)) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_SMWR: begin
					cur_q.eb <= quo_q[EW-1:0];
					cur_q.lb <= now_q - cur_q.st;
					scan_q   <= '0;
					any_q    <= 1'b0;
					state_q  <= ST_SADDR;
				end
				ST_SADDR: begin
					if (!queued_q[scan_q]) begin
						if (last_slot) begin
							state_q <= ST_FIN;
						end else begin
							scan_q <= scan_q + SW'(1);
						end
					end else begin
						state_q <= ST_SDATA;
					end
				end
				ST_SDATA: begin
					if (scan_q == '0) begin
						e0_q <= rec.eb;
						if (last_slot) begin
							state_q <= ST_FIN;
						end else begin
							scan_q  <= scan_q + SW'(1);
							state_q <= ST_SADDR;
						end
					end else begin
						cand_q <= rec;
						if (!any_q || rec.eb < min_q) begin
							min_q <= rec.eb;
						end
						a_q     <= AW'(rec.eb) + (AW'(1) << F);
						b_q     <= BPW'(wait_w);
						acc_q   <= '0;
						dcnt_q  <= DW'(ND - 1);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					acc_q  <= PW'(acc_q << DIGIT_BITS) + PW'(prod);
					b_q    <= b_q << DIGIT_BITS;
					dcnt_q <= dcnt_q - DW'(1);
					if (dcnt_q == '0) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (!any_q || acc_q < best_q) begin
						best_q     <= acc_q;
						pick_q     <= scan_q;
						pick_rec_q <= cand_q;
					end
					any_q <= 1'b1;
					if (last_slot) begin
						state_q <= ST_FIN;
					end else begin
						scan_q  <= scan_q + SW'(1);
						state_q <= ST_SADDR;
					end
				end
				ST_FIN: begin
					if (!any_q) begin
						fork_q  <= e0_q;
						sw_q    <= (run_q != '0);
						run_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						fork_q <= min_q;
						if (pick_q != run_q) begin
							state_q <= ST_WPICK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WPICK: begin
					run_q   <= pick_q;
					sw_q    <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid || !rsp_stall) begin
						rsp_valid     <= 1'b1;
						rsp.next_task <= 4'(run_q);
						rsp.switched  <= sw_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/bgts_chk.sv]
// Port-level checker for the burst-goodness task scheduler, with its bind.
module bgts_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input bgts_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input bgts_pkg::rsp_t rsp
);
	import bgts_pkg::*;

	logic [3:0] last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (rsp_valid && !rsp_stall) begin
			last_q <= rsp.next_task;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("accepted two transactions back to back");

	a_switch_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.switched |-> rsp.next_task == last_q)
		else $error("running task changed without switched");

	a_switch_change: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && rsp.switched |-> rsp.next_task != last_q)
		else $error("switched set but running task unchanged");

endmodule

bind burst_goodness_task_scheduler bgts_chk u_bgts_chk (.*);

[dv/burst_goodness_task_scheduler_checker.sv]
// Predicts and checks scheduler responses from the observed request and response transactions.
module burst_goodness_task_scheduler_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  bgts_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  bgts_pkg::rsp_t rsp,
	output int             errors,
	output int             pending
);
	import bgts_pkg::*;

	localparam int SLOTS = 16;
	localparam int FRAC = 8;

	logic        queued [SLOTS];
	logic [39:0] est_burst [SLOTS];
	logic [31:0] last_burst [SLOTS];
	logic [31:0] start_t [SLOTS];
	logic [31:0] stop_t [SLOTS];
	logic [31:0] queue_t [SLOTS];
	logic [3:0]  running;
	logic [39:0] seed_burst;
	rsp_t        rsp_q [$];

	function automatic logic [39:0] smoothed(logic [31:0] burst, logic [39:0] e);
		logic [63:0] x;
		x = {32'd0, burst} << FRAC;
		return 40'((2 * x + {24'd0, e}) / 3);
	endfunction

	function automatic logic [127:0] goodness_of(int s, logic [31:0] now);
		logic [63:0] w;
		w = {32'd0, 32'(now - queue_t[s])} + 64'd1;
		return {88'd0, est_burst[s]} * {64'd0, w} + ({64'd0, w} << FRAC);
	endfunction

	task automatic schedule_step(req_t r);
		rsp_t        res;
		int          cur;
		int          pick;
		bit          any;
		logic [39:0] min_e;
		logic [127:0] best, g;
		cur = running;
		pick = 0;
		any = 0;
		min_e = '0;
		best = '0;
		res.switched = 0;
		if (r.op == OP_SCHED) begin
			est_burst[cur] = smoothed(last_burst[cur], est_burst[cur]);
			last_burst[cur] = r.time_now - start_t[cur];
			for (int s = 1; s < SLOTS; s++) begin
				if (!queued[s])
					continue;
				g = goodness_of(s, r.time_now);
				if (!any || est_burst[s] < min_e)
					min_e = est_burst[s];
				if (!any || g < best) begin
					best = g;
					pick = s;
				end
				any = 1;
			end
			if (!any) begin
				seed_burst = est_burst[0];
				res.switched = (cur != 0);
				running = 4'd0;
			end else begin
				seed_burst = min_e;
				if (pick != cur) begin
					stop_t[cur] = r.time_now;
					start_t[pick] = r.time_now;
					running = 4'(pick);
					res.switched = 1;
				end
			end
		end else if (r.task_slot != 0) begin
			case (r.op)
				OP_NEW: begin
					start_t[r.task_slot] = 0;
					stop_t[r.task_slot] = 0;
					last_burst[r.task_slot] = 0;
					est_burst[r.task_slot] = seed_burst;
					queue_t[r.task_slot] = r.time_now;
					queued[r.task_slot] = 1;
				end
				OP_ACT: if (!queued[r.task_slot]) begin
					queued[r.task_slot] = 1;
					if (queue_t[r.task_slot] > stop_t[r.task_slot])
						stop_t[r.task_slot] = queue_t[r.task_slot];
					queue_t[r.task_slot] = r.time_now;
				end
				default: if (queued[r.task_slot]) begin
					queued[r.task_slot] = 0;
					stop_t[r.task_slot] = r.time_now;
				end
			endcase
		end
		res.next_task = running;
		rsp_q.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				queued[s] = (s == 0);
				est_burst[s] = '0;
				last_burst[s] = '0;
				start_t[s] = '0;
				stop_t[s] = '0;
				queue_t[s] = '0;
			end
			running = 0;
			seed_burst = '0;
			rsp_q.delete();
			errors = 0;
		end else begin
			if (req_valid && !req_stall)
				schedule_step(req);
			if (rsp_valid && !rsp_stall) begin
				if (rsp_q.size() == 0) begin
					$error("unexpected transaction: next_task %0d", rsp.next_task);
					errors++;
				end else begin
					want = rsp_q.pop_front();
					if (rsp.next_task !== want.next_task) begin
						$error("next_task: expected %0d, actual %0d", want.next_task,
							rsp.next_task);
						errors++;
					end
					if (rsp.switched !== want.switched) begin
						$error("switched: expected %0d, actual %0d", want.switched,
							rsp.switched);
						errors++;
					end
				end
			end
		end
		pending = rsp_q.size();
	end
endmodule

[dv/burst_goodness_task_scheduler_test.sv]
// Stimulus, watchdog and verdict for the burst-goodness task scheduler.
module burst_goodness_task_scheduler_test;
	import bgts_pkg::*;

	localparam int RANDOM_ITEMS = 800;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int   errors;
	int   pending;
	bit   sending_done;
	bit   long_hold;
	int   idle_cycles;
	logic [31:0] clock_now;

	burst_goodness_task_scheduler dut (.*);

	burst_goodness_task_scheduler_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic send(op_t op, logic [3:0] slot, logic [31:0] t);
		int gap;
		gap = $urandom_range(0, 19) * $urandom_range(0, 1);
		if (gap > 0) begin
			req_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1;
		req <= '{op: op, task_slot: slot, time_now: t};
		do @(posedge clk); while (req_stall);
	endtask

	// mostly a monotonic clock with random steps, plus occasional wild values
	function automatic logic [31:0] next_time();
		if ($urandom_range(0, 15) == 0)
			clock_now = $urandom;
		else
			clock_now += $urandom_range(0, 3000);
		return clock_now;
	endfunction

	initial begin
		arst_n = 0;
		req_valid = 0;
		req = '0;
		sending_done = 0;
		clock_now = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: seed alone, edge slots and times, ignored ops
		send(OP_SCHED, 4'd0, 32'd0);
		send(OP_NEW, 4'd0, 32'd5);
		send(OP_NEW, 4'd15, 32'hFFFF_FFFF);
		send(OP_NEW, 4'd1, 32'd10);
		send(OP_SCHED, 4'd0, 32'd100);
		send(OP_SCHED, 4'd0, 32'd100);
		send(OP_ACT, 4'd1, 32'd120);
		send(OP_DEACT, 4'd1, 32'd200);
		send(OP_DEACT, 4'd1, 32'd210);
		send(OP_SCHED, 4'd0, 32'd300);
		send(OP_ACT, 4'd1, 32'd400);
		send(OP_NEW, 4'd2, 32'd400);
		send(OP_SCHED, 4'd15, 32'd0);
		send(OP_DEACT, 4'd15, 32'd500);
		send(OP_DEACT, 4'd1, 32'd600);
		send(OP_DEACT, 4'd2, 32'd600);
		send(OP_SCHED, 4'd0, 32'hFFFF_FFFF);
		send(OP_NEW, 4'd7, 32'hAAAA_AAAA);
		send(OP_NEW, 4'd8, 32'h5555_5555);
		send(OP_SCHED, 4'd0, 32'h5555_6000);
		send(OP_NEW, 4'd8, 32'h5555_7000);
		send(OP_SCHED, 4'd0, 32'h6000_0000);
		clock_now = 32'h6000_0000;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send(OP_SCHED, 4'($urandom), next_time());
				4, 5:       send(OP_NEW, 4'($urandom), next_time());
				6, 7:       send(OP_ACT, 4'($urandom), next_time());
				default:    send(OP_DEACT, 4'($urandom), next_time());
			endcase
		end
		req_valid <= 0;
		sending_done = 1;
	end

	initial begin
		int hold;
		int rsp_count;
		rsp_stall = 1;
		long_hold = 0;
		rsp_count = 0;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, 19);
			// one long hold while the sender keeps offering, so the block backs up
			if (!long_hold && rsp_count >= 50) begin
				long_hold = 1;
				hold = 300;
			end
			if (hold > 0) begin
				rsp_stall <= 1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 0;
			do @(posedge clk); while (!rsp_valid);
			rsp_count++;
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		wait (sending_done);
		wait (pending == 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

[filelist.f]
hw/rtl/bgts_pkg.sv
hw/rtl/bgts_ram.sv
hw/rtl/burst_goodness_task_scheduler.sv
hw/rtl/bgts_chk.sv
dv/burst_goodness_task_scheduler_checker.sv
dv/burst_goodness_task_scheduler_test.sv
